// File: hw/rtl/kft_pkg.sv
// Package for the keyword flow tracker: widths, keyword tables, codes and
// the types shared by the parser, the flow table and the top level.
// Depends on nothing.
package kft_pkg;

   localparam int unsigned BUCKETS_DEF = 1024;
   localparam int unsigned WAYS_DEF = 4;
   localparam int unsigned SEARCH_WINDOW_DEF = 100;
   localparam logic [15:0] TIMEOUT_RESET = 16'd60;

   localparam int unsigned KW_COUNT = 5;
   localparam logic [2:0] KW_NONE = 3'd5;

   localparam logic [1:0] ST_NONE = 2'd0;
   localparam logic [1:0] ST_HIT = 2'd1;
   localparam logic [1:0] ST_ADDED = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic CSR_LINK_KIND = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_TCP = 2'd1;
   localparam logic [1:0] KIND_UDP = 2'd2;

   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_VLAN = 16'h8100;
   localparam logic [15:0] ETH_MPLS = 16'h8847;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   // Keyword text, first character in the lowest byte, zero padded.
   localparam logic [8*9-1:0] KW_TEXT [KW_COUNT] = '{
      {8'h00, " GSMVIRP"},
      {8'h00, 8'h00, " ECITON"},
      " //NWOD: ",
      " //PTFE: ",
      {8'h00, 8'h00, 8'h00, "NOITCA"}
   };
   localparam int unsigned KW_LEN [KW_COUNT] = '{8, 7, 9, 9, 6};

   // Parsed packet summary handed to the flow table at the last byte.
   typedef struct packed {
      logic        valid;
      logic [31:0] saddr;
      logic [31:0] daddr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic        tcp;
      logic        fin;
      logic [2:0]  kw;
      logic [31:0] now;
   } pkt_type;

   typedef enum logic [1:0] {
      TS_IDLE,
      TS_READ,
      TS_WAIT,
      TS_DECIDE
   } tbl_state_type;

endpackage

// File: hw/rtl/keyword_flow_tracker.sv
// Top level of the keyword flow tracker: configuration registers, the byte
// parser and the flow table. Depends on kft_pkg, kft_parser and kft_table.
//
//   Channel  Ports                         Handshake
//   req      data_byte, last_byte, now     start high while busy low
//   rsp      accept, keyword_found, status strobe for one cycle, no stall
//   csr      we, index, data               write at any edge with we high
//
// Header and payload bytes are taken while busy is low. At a last byte that
// reaches the payload, the flow table reads the bucket (one memory read),
// decides and writes back; busy stays high through the READ, WAIT and
// DECIDE states and the result strobes in DECIDE. Other packets answer in
// the cycle after their last byte. After reset, a clearing pass over the
// BUCKETS rows of the valid memory keeps busy high until it ends. The receiver cannot stall.
module keyword_flow_tracker #(
   parameter int unsigned BUCKETS = kft_pkg::BUCKETS_DEF,
   parameter int unsigned WAYS = kft_pkg::WAYS_DEF,
   parameter int unsigned SEARCH_WINDOW = kft_pkg::SEARCH_WINDOW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_now_seconds,
   output logic        rsp_strobe,
   output logic        rsp_accept,
   output logic [2:0]  rsp_keyword_found,
   output logic [1:0]  rsp_flow_status,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic link_kind_ff;
   logic [15:0] timeout_ff;
   logic take;
   kft_pkg::pkt_type pkt;
   logic pkt_done, pkt_track;
   logic tbl_busy, tbl_done;
   logic [1:0] tbl_status;
   logic [2:0] kw_ff;
   logic quick_ff;

   assign take = start && !busy;
   assign busy = tbl_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_kind_ff <= 1'b0;
         timeout_ff <= kft_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            kft_pkg::CSR_LINK_KIND: link_kind_ff <= csr_data[0];
            kft_pkg::CSR_TIMEOUT:   timeout_ff <= csr_data;
            default:                ;
         endcase
      end
   end

   kft_parser #(.SEARCH_WINDOW(SEARCH_WINDOW)) u_parser (
      .clock(clock), .reset(reset), .byte_valid(take),
      .data_byte(req_data_byte), .last_byte(req_last_byte),
      .now_seconds(req_now_seconds), .link_kind(link_kind_ff),
      .pkt(pkt), .pkt_done(pkt_done), .pkt_track(pkt_track)
   );

   kft_table #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_table (
      .clock(clock), .reset(reset), .start(pkt_done && pkt_track),
      .pkt(pkt), .timeout(timeout_ff), .busy(tbl_busy),
      .done(tbl_done), .status(tbl_status)
   );

   // Untracked packets answer on their own in the next cycle; the keyword
   // index of a tracked packet is held until the table finishes.
   always_ff @(posedge clock) begin
      if (reset) quick_ff <= 1'b0;
      else quick_ff <= pkt_done && !pkt_track;
      if (pkt_done) kw_ff <= pkt.kw;
   end

   assign rsp_strobe = quick_ff || tbl_done;
   assign rsp_accept = tbl_done && (tbl_status != kft_pkg::ST_NONE);
   assign rsp_flow_status = tbl_done ? tbl_status : kft_pkg::ST_NONE;
   assign rsp_keyword_found = tbl_done ? kw_ff : kft_pkg::KW_NONE;

endmodule

// File: hw/rtl/kft_parser.sv
// Byte parser of the keyword flow tracker: link, IPv4 and L4 headers plus
// the keyword scan over the payload window. Depends on kft_pkg.
module kft_parser #(
   parameter int unsigned SEARCH_WINDOW = kft_pkg::SEARCH_WINDOW_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   input  logic [31:0]         now_seconds,
   input  logic                link_kind,
   output kft_pkg::pkt_type    pkt,
   output logic                pkt_done,
   output logic                pkt_track
);

   logic [15:0] pos_ff, pos_in;
   logic [7:0]  rb_ff [9];
   logic [7:0]  rb_in [9];
   logic [31:0] sa_ff, sa_in, da_ff, da_in;
   logic [15:0] sp_ff, sp_in, dp_ff, dp_in;
   logic [3:0]  ihl_ff, ihl_in, doff_ff, doff_in;
   logic [1:0]  kind_ff, kind_in;
   logic        fin_ff, fin_in, drop_ff, drop_in;
   logic [4:0]  ipoff_ff, ipoff_in;
   logic [4:0]  hits_ff, hits_in;
   logic [4:0]  hits_fin;
   logic [15:0] w1;
   logic [16:0] l4, ps, ps_cur;
   logic        ps_ok, ps_ok_cur;
   logic [16:0] rel, r4, seen;
   logic [2:0]  kw;
   logic        eq;

   assign w1 = {rb_ff[0], data_byte};

   always_comb begin
      l4 = 17'(ipoff_ff) + 17'({ihl_ff, 2'b00});
      ps = 17'(ipoff_in) + 17'({ihl_in, 2'b00})
         + ((kind_in == kft_pkg::KIND_UDP) ? 17'd8 : 17'({doff_in, 2'b00}));
      ps_ok = (ipoff_in != 5'd0) && (ihl_in != 4'd0) &&
         ((kind_in == kft_pkg::KIND_UDP) ||
          (kind_in == kft_pkg::KIND_TCP && doff_in != 4'd0));
      ps_cur = 17'(ipoff_ff) + 17'({ihl_ff, 2'b00})
         + ((kind_ff == kft_pkg::KIND_UDP) ? 17'd8 : 17'({doff_ff, 2'b00}));
      ps_ok_cur = (ipoff_ff != 5'd0) && (ihl_ff != 4'd0) &&
         ((kind_ff == kft_pkg::KIND_UDP) ||
          (kind_ff == kft_pkg::KIND_TCP && doff_ff != 4'd0));
   end

   always_comb begin
      pos_in = pos_ff;
      sa_in = sa_ff; da_in = da_ff; sp_in = sp_ff; dp_in = dp_ff;
      ihl_in = ihl_ff; doff_in = doff_ff; kind_in = kind_ff;
      fin_in = fin_ff; drop_in = drop_ff; ipoff_in = ipoff_ff;
      hits_in = hits_ff;
      eq = 1'b0;
      rel = 17'(pos_ff) - 17'(ipoff_ff);
      r4 = 17'(pos_ff) - l4;
      seen = 17'(pos_ff) - ps + 17'd1;
      rb_in = rb_ff;
      if (byte_valid) begin
         rb_in[0] = data_byte;
         for (int i = 1; i < 9; i++) rb_in[i] = rb_ff[i-1];
         if (!drop_ff) begin
            if (ipoff_ff == 5'd0) begin
               if (link_kind) begin
                  if (pos_ff == 16'd3) begin
                     if (w1 == kft_pkg::ETH_IPV4) ipoff_in = 5'd4;
                     else drop_in = 1'b1;
                  end
               end else if (pos_ff == 16'd13) begin
                  if (w1 == kft_pkg::ETH_MPLS) ipoff_in = 5'd18;
                  else if (w1 == kft_pkg::ETH_IPV4) ipoff_in = 5'd14;
                  else if (w1 != kft_pkg::ETH_VLAN) drop_in = 1'b1;
               end else if (pos_ff == 16'd17) begin
                  if (w1 == kft_pkg::ETH_MPLS) ipoff_in = 5'd22;
                  else if (w1 == kft_pkg::ETH_IPV4) ipoff_in = 5'd18;
                  else drop_in = 1'b1;
               end
            end else if (pos_ff >= 16'(ipoff_ff)) begin
               if (rel == 17'd0) begin
                  if (data_byte[3:0] < 4'd5) drop_in = 1'b1;
                  else ihl_in = data_byte[3:0];
               end else if (rel == 17'd9) begin
                  if (data_byte == kft_pkg::PROTO_TCP) kind_in = kft_pkg::KIND_TCP;
                  else if (data_byte == kft_pkg::PROTO_UDP) kind_in = kft_pkg::KIND_UDP;
                  else drop_in = 1'b1;
               end else begin
                  if (rel == 17'd15) sa_in = {rb_ff[2], rb_ff[1], w1};
                  if (rel == 17'd19) da_in = {rb_ff[2], rb_ff[1], w1};
                  if (kind_ff != kft_pkg::KIND_NONE && 17'(pos_ff) >= l4) begin
                     if (r4 == 17'd1) sp_in = w1;
                     else if (r4 == 17'd3) dp_in = w1;
                     else if (kind_ff == kft_pkg::KIND_TCP && r4 == 17'd12) begin
                        if (data_byte[7:4] < 4'd5) drop_in = 1'b1;
                        else doff_in = data_byte[7:4];
                     end else if (kind_ff == kft_pkg::KIND_TCP && r4 == 17'd13)
                        fin_in = data_byte[0];
                     // The scan only runs when this byte set no header item
                     // that ends the pass, so the current fields apply.
                     if (!(kind_ff == kft_pkg::KIND_TCP && r4 == 17'd12) &&
                         ps_ok_cur && 17'(pos_ff) >= ps_cur &&
                         17'(pos_ff) - ps_cur < 17'(SEARCH_WINDOW)) begin
                        seen = 17'(pos_ff) - ps_cur + 17'd1;
                        for (int k = 0; k < kft_pkg::KW_COUNT; k++) begin
                           eq = 1'b1;
                           for (int i = 0; i < 9; i++)
                              if (i < kft_pkg::KW_LEN[k] &&
                                  rb_in[kft_pkg::KW_LEN[k]-1-i] !=
                                  kft_pkg::KW_TEXT[k][8*i +: 8])
                                 eq = 1'b0;
                           if (eq && seen >= 17'(kft_pkg::KW_LEN[k]))
                              hits_in[k] = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         if (pos_ff != 16'hFFFF) pos_in = pos_ff + 16'd1;
      end
   end

   always_comb begin
      kw = kft_pkg::KW_NONE;
      for (int k = kft_pkg::KW_COUNT - 1; k >= 0; k--)
         if (hits_in[k]) kw = 3'(k);
      hits_fin = hits_in;
   end

   assign pkt_done = byte_valid && last_byte;
   assign pkt_track = !drop_in && ps_ok && (17'(pos_ff) >= ps);
   assign pkt.valid = pkt_track;
   assign pkt.saddr = sa_in;
   assign pkt.daddr = da_in;
   assign pkt.sport = sp_in;
   assign pkt.dport = dp_in;
   assign pkt.tcp = (kind_in == kft_pkg::KIND_TCP);
   assign pkt.fin = fin_in;
   assign pkt.kw = (hits_fin == 5'd0) ? kft_pkg::KW_NONE : kw;
   assign pkt.now = now_seconds;

   always_ff @(posedge clock) begin
      if (reset || pkt_done) begin
         pos_ff <= '0; sa_ff <= '0; da_ff <= '0; sp_ff <= '0; dp_ff <= '0;
         ihl_ff <= '0; doff_ff <= '0; kind_ff <= '0; fin_ff <= 1'b0;
         drop_ff <= 1'b0; ipoff_ff <= '0; hits_ff <= '0;
         for (int i = 0; i < 9; i++) rb_ff[i] <= '0;
      end else begin
         pos_ff <= pos_in; sa_ff <= sa_in; da_ff <= da_in;
         sp_ff <= sp_in; dp_ff <= dp_in; ihl_ff <= ihl_in;
         doff_ff <= doff_in; kind_ff <= kind_in; fin_ff <= fin_in;
         drop_ff <= drop_in; ipoff_ff <= ipoff_in; hits_ff <= hits_in;
         rb_ff <= rb_in;
      end
   end

endmodule

// File: hw/rtl/kft_table.sv
// Flow table of the keyword flow tracker: a bucket-wide memory read, a
// decision over the ways and a bucket write-back. Depends on kft_pkg.
module kft_table #(
   parameter int unsigned BUCKETS = kft_pkg::BUCKETS_DEF,
   parameter int unsigned WAYS = kft_pkg::WAYS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  kft_pkg::pkt_type pkt,
   input  logic [15:0]      timeout,
   output logic             busy,
   output logic             done,
   output logic [1:0]       status
);

   localparam int unsigned BW = $clog2(BUCKETS);
   localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned EW = 64 + 34 + 32;
   localparam int unsigned ROW = EW * WAYS;

   logic [ROW-1:0] mem [BUCKETS];
   logic [WAYS-1:0] vld_mem [BUCKETS];
   logic [ROW-1:0] row_ff;
   logic [WAYS-1:0] vrow_ff;
   logic [BW:0] clr_ff;
   kft_pkg::tbl_state_type st_ff, st_in;
   kft_pkg::pkt_type pk_ff;
   logic [BW-1:0] bkt_ff;
   logic [31:0] sum;
   logic [ROW-1:0] row_new;
   logic [WAYS-1:0] v_new;
   logic [1:0] st_res;
   logic wr;
   logic hit_f;
   logic [WW-1:0] hit_w, free_w;
   logic free_f;
   logic [63:0] ea;
   logic [33:0] ep;
   logic [31:0] et;

   assign sum = pkt.saddr + pkt.daddr;
   assign busy = (st_ff != kft_pkg::TS_IDLE) || !clr_ff[BW];

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         kft_pkg::TS_IDLE:   if (start && clr_ff[BW]) st_in = kft_pkg::TS_READ;
         kft_pkg::TS_READ:   st_in = kft_pkg::TS_WAIT;
         kft_pkg::TS_WAIT:   st_in = kft_pkg::TS_DECIDE;
         kft_pkg::TS_DECIDE: st_in = kft_pkg::TS_IDLE;
         default:            st_in = kft_pkg::TS_IDLE;
      endcase
   end

   always_comb begin
      hit_f = 1'b0; hit_w = '0; free_f = 1'b0; free_w = '0;
      row_new = row_ff; v_new = vrow_ff; st_res = kft_pkg::ST_NONE;
      for (int w = 0; w < WAYS; w++) begin
         ea = row_ff[w*EW +: 64];
         ep = row_ff[w*EW+64 +: 34];
         if (!hit_f && vrow_ff[w] && ep[32] == pk_ff.tcp &&
             ((ea == {pk_ff.saddr, pk_ff.daddr} &&
               ep[31:0] == {pk_ff.sport, pk_ff.dport}) ||
              (ea == {pk_ff.daddr, pk_ff.saddr} &&
               ep[31:0] == {pk_ff.dport, pk_ff.sport}))) begin
            hit_f = 1'b1; hit_w = WW'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         et = row_ff[w*EW+98 +: 32];
         if (!(hit_f && hit_w == WW'(w)) && vrow_ff[w] &&
             (pk_ff.now - et) > 32'(timeout))
            v_new[w] = 1'b0;
      end
      for (int w = WAYS - 1; w >= 0; w--)
         if (!v_new[w]) begin free_f = 1'b1; free_w = WW'(w); end
      if (hit_f) begin
         row_new[32'(hit_w)*EW+98 +: 32] = pk_ff.now;
         if (pk_ff.tcp && pk_ff.fin) v_new[hit_w] = 1'b0;
         st_res = kft_pkg::ST_HIT;
      end else if (pk_ff.kw != kft_pkg::KW_NONE) begin
         if (free_f) begin
            row_new[32'(free_w)*EW +: EW] = {pk_ff.now, 1'b1, pk_ff.tcp,
               pk_ff.sport, pk_ff.dport, pk_ff.saddr, pk_ff.daddr};
            v_new[free_w] = 1'b1;
            st_res = kft_pkg::ST_ADDED;
         end else st_res = kft_pkg::ST_FULL;
      end
   end

   assign wr = (st_ff == kft_pkg::TS_DECIDE);
   assign done = wr;
   assign status = st_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= kft_pkg::TS_IDLE;
         clr_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (!clr_ff[BW]) clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == kft_pkg::TS_IDLE && start) begin
         pk_ff <= pkt;
         bkt_ff <= sum[BW-1:0];
      end
      if (st_ff == kft_pkg::TS_READ) begin
         row_ff <= mem[bkt_ff];
         vrow_ff <= vld_mem[bkt_ff];
      end
      if (wr) mem[bkt_ff] <= row_new;
      if (!clr_ff[BW]) vld_mem[clr_ff[BW-1:0]] <= '0;
      else if (wr) vld_mem[bkt_ff] <= v_new;
   end

endmodule
